/* hdl/lsf_pkg.sv */
// Shared types, constants and saturating Q32.32 helpers for the line fit block.
package lsf_pkg;

    localparam logic [63:0] MAG_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] FORECAST_X_RESET = 32'd800000;
    localparam int          DIV_STEPS = 96;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_VAR = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               last_point;
    } sample_t;

    typedef struct packed {
        logic signed [63:0] slope;
        logic signed [63:0] intercept;
        logic signed [63:0] forecast_y;
        logic        [1:0]  fit_status;
    } result_t;

    // value plus saturation flag
    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } sval_t;

    // completion pulse and saturation flag from an arithmetic unit
    typedef struct packed {
        logic done;
        logic sat;
    } unit_stat_t;

    function automatic logic [63:0] mag_of(logic [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic sval_t from_mag(logic [63:0] mag, logic neg, logic over);
        sval_t       r;
        logic [63:0] limit;
        logic [63:0] m;
        limit = neg ? MAG_MIN : Q_MAX;
        r.sat = over || (mag > limit);
        m     = r.sat ? limit : mag;
        r.val = neg ? (~m + 64'd1) : m;
        return r;
    endfunction

    function automatic sval_t sat_add(logic [63:0] a, logic [63:0] b);
        sval_t       r;
        logic [63:0] s;
        s     = a + b;
        r.sat = (a[63] == b[63]) && (s[63] != a[63]);
        r.val = r.sat ? (a[63] ? MAG_MIN : Q_MAX) : s;
        return r;
    endfunction

    function automatic sval_t sat_sub(logic [63:0] a, logic [63:0] b);
        sval_t       r;
        logic [63:0] d;
        d     = a - b;
        r.sat = (a[63] != b[63]) && (d[63] != a[63]);
        r.val = r.sat ? (a[63] ? MAG_MIN : Q_MAX) : d;
        return r;
    endfunction

endpackage

/* hdl/lsf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/lsf_mul.sv */
// Iterative Q32.32 multiplier: four 32x32 partial products, saturating result.
module lsf_mul import lsf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p,
    output unit_stat_t  stat
);

    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [1:0]   step_reg;
    logic         run_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic         pp_vld_reg, pp_last_reg;
    logic [127:0] acc_reg;
    logic         fin_reg;
    logic         done_reg;
    logic         sat_reg;
    logic [63:0]  p_reg;

    logic [31:0]  a_sel, b_sel;
    logic [127:0] pp_shifted;
    sval_t        res;

    assign a_sel = step_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
    assign b_sel = step_reg[1] ? mb_reg[63:32] : mb_reg[31:0];

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = 128'd0;
        endcase
    end

    // keep bits 95:32, anything above is overflow
    assign res = from_mag(acc_reg[95:32], neg_reg, |acc_reg[127:96]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            step_reg    <= 2'd0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            fin_reg     <= 1'b0;
            done_reg    <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            pp_vld_reg  <= run_reg;
            pp_last_reg <= run_reg && (step_reg == 2'd3);
            fin_reg     <= pp_vld_reg && pp_last_reg;
            done_reg    <= fin_reg;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                end
            end
            if (fin_reg)
            begin
                sat_reg <= res.sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= mag_of(a);
            mb_reg  <= mag_of(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= 128'd0;
        end
        else if (pp_vld_reg)
        begin
            acc_reg <= acc_reg + pp_shifted;
        end
        if (run_reg)
        begin
            pp_reg    <= a_sel * b_sel;
            pp_sh_reg <= 2'({1'b0, step_reg[0]} + {1'b0, step_reg[1]});
        end
        if (fin_reg)
        begin
            p_reg <= res.val;
        end
    end

    assign p         = p_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

endmodule

/* hdl/lsf_div.sv */
// Restoring divider, one quotient bit per cycle: (|a| << 32) / |b|, saturating.
module lsf_div import lsf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] q,
    output unit_stat_t  stat
);

    localparam int SW = $clog2(DIV_STEPS);

    logic [95:0]   dq_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   mb_reg;
    logic          neg_reg;
    logic [SW-1:0] cnt_reg;
    logic          run_reg;
    logic          fin_reg;
    logic          done_reg;
    logic          sat_reg;
    logic [63:0]   q_reg;

    logic [63:0]   mb_in;
    logic          div_zero;
    logic [64:0]   shifted;
    logic [64:0]   diff;
    logic          ge;
    sval_t         res;

    assign mb_in    = mag_of(b);
    // divide by zero gives zero, done on the next cycle
    assign div_zero = start && (mb_in == 64'd0);
    assign shifted  = {rem_reg, dq_reg[95]};
    assign diff     = shifted - {1'b0, mb_reg};
    assign ge       = !diff[64];
    // quotient above 64 bits is overflow
    assign res      = from_mag(dq_reg[63:0], neg_reg, |dq_reg[95:64]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            fin_reg  <= !start && run_reg && (cnt_reg == SW'(DIV_STEPS - 1));
            done_reg <= fin_reg || div_zero;
            if (start)
            begin
                cnt_reg <= '0;
                run_reg <= !div_zero;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + SW'(1);
                if (cnt_reg == SW'(DIV_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
            if (fin_reg)
            begin
                sat_reg <= res.sat;
            end
            else if (div_zero)
            begin
                sat_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= {mag_of(a), 32'd0};
            rem_reg <= 64'd0;
            mb_reg  <= mb_in;
            neg_reg <= a[63] ^ b[63];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[63:0] : shifted[63:0];
            dq_reg  <= {dq_reg[94:0], ge};
        end
        if (fin_reg)
        begin
            q_reg <= res.val;
        end
        else if (div_zero)
        begin
            q_reg <= 64'd0;
        end
    end

    assign q         = q_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

endmodule

/* hdl/least_squares_line_fit.sv */
// Top level of the least-squares line fit: sample store, sequencer, result register.
// Sequence: a non-last request is written to the store, no result. The last one starts
//   the fit, and done marks its end: sums over the pairs, two divisions for the means,
//   deviations and two products a pair, then a slope division and two more products
//   (all skipped on zero x variance). busy is high until done; the receiver cannot stall it.
// Throughput: one request per cycle while filling; a new set may start in the done cycle.
// Reset (rst_n, async, active low): sequencer, count, flags cleared, forecast_x = 800000.
module least_squares_line_fit import lsf_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sample_t            sample,
    output logic               done,
    output result_t            result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [31:0] cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = 32 + AW;   // running sum of up to MAX_POINTS samples

    typedef enum logic [19:0] {
        S_IDLE  = 20'b0000_0000_0000_0000_0001,
        S_RD1   = 20'b0000_0000_0000_0000_0010,
        S_ACC1  = 20'b0000_0000_0000_0000_0100,
        S_MX_GO = 20'b0000_0000_0000_0000_1000,
        S_MX_WT = 20'b0000_0000_0000_0001_0000,
        S_MY_GO = 20'b0000_0000_0000_0010_0000,
        S_MY_WT = 20'b0000_0000_0000_0100_0000,
        S_RD2   = 20'b0000_0000_0000_1000_0000,
        S_DEV   = 20'b0000_0000_0001_0000_0000,
        S_CR_GO = 20'b0000_0000_0010_0000_0000,
        S_CR_WT = 20'b0000_0000_0100_0000_0000,
        S_SQ_GO = 20'b0000_0000_1000_0000_0000,
        S_SQ_WT = 20'b0000_0001_0000_0000_0000,
        S_CHK   = 20'b0000_0010_0000_0000_0000,
        S_SL_GO = 20'b0000_0100_0000_0000_0000,
        S_SL_WT = 20'b0000_1000_0000_0000_0000,
        S_IC_GO = 20'b0001_0000_0000_0000_0000,
        S_IC_WT = 20'b0010_0000_0000_0000_0000,
        S_FY_GO = 20'b0100_0000_0000_0000_0000,
        S_FY_WT = 20'b1000_0000_0000_0000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [SW-1:0] sumx_reg, sumx_next;
    logic [SW-1:0] sumy_reg, sumy_next;
    logic [63:0]   mean_x_reg, mean_x_next;
    logic [63:0]   mean_y_reg, mean_y_next;
    logic [63:0]   dx_reg, dx_next;
    logic [63:0]   dy_reg, dy_next;
    logic [63:0]   cross_reg, cross_next;
    logic [63:0]   square_reg, square_next;
    logic [63:0]   slope_reg, slope_next;
    logic [63:0]   icpt_reg, icpt_next;
    logic [31:0]   fx_reg;
    logic          sat_reg, sat_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    // sample store
    logic          accept;
    logic          room;
    logic          ram_we;
    logic [63:0]   ram_rdata;
    logic [31:0]   rd_x, rd_y;
    logic [CW-1:0] last_idx;

    // shared arithmetic units
    logic          mul_start, div_start;
    logic [63:0]   mul_a, mul_b, mul_p;
    logic [63:0]   div_a, div_b, div_q;
    unit_stat_t    mul_stat, div_stat;

    sval_t         dx_s, dy_s, acc_s, icpt_s, fy_s;

    assign accept   = start && (state_reg == S_IDLE);
    assign room     = (cnt_reg < CW'(MAX_POINTS));
    assign ram_we   = accept && room;
    assign rd_x     = ram_rdata[63:32];
    assign rd_y     = ram_rdata[31:0];
    assign last_idx = n_reg - CW'(1);

    lsf_ram #(
        .WIDTH (64),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({sample.x_value, sample.y_value}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    lsf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .stat  (mul_stat)
    );

    lsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .q     (div_q),
        .stat  (div_stat)
    );

    // operand select for the shared units
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = slope_reg;
        mul_b     = mean_x_reg;
        case (state_reg)
            S_CR_GO:
            begin
                mul_start = 1'b1;
                mul_a     = dx_reg;
                mul_b     = dy_reg;
            end
            S_SQ_GO:
            begin
                mul_start = 1'b1;
                mul_a     = dx_reg;
                mul_b     = dx_reg;
            end
            S_IC_GO:
            begin
                mul_start = 1'b1;
            end
            S_FY_GO:
            begin
                mul_start = 1'b1;
                mul_b     = {fx_reg, 32'd0};
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_a     = {{(64 - SW){sumx_reg[SW-1]}}, sumx_reg};
        div_b     = {{(64 - CW){1'b0}}, n_reg};
        case (state_reg)
            S_MX_GO:
            begin
                div_start = 1'b1;
            end
            S_MY_GO:
            begin
                div_start = 1'b1;
                div_a     = {{(64 - SW){sumy_reg[SW-1]}}, sumy_reg};
            end
            S_SL_GO:
            begin
                div_start = 1'b1;
                div_a     = cross_reg;
                div_b     = square_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // deviations from the means, the running accumulations, intercept and forecast
    assign dx_s   = sat_sub({rd_x, 32'd0}, mean_x_reg);
    assign dy_s   = sat_sub({rd_y, 32'd0}, mean_y_reg);
    assign acc_s  = sat_add((state_reg == S_CR_WT) ? cross_reg : square_reg, mul_p);
    assign icpt_s = sat_sub(mean_y_reg, mul_p);
    assign fy_s   = sat_add(icpt_reg, mul_p);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        sumx_next   = sumx_reg;
        sumy_next   = sumy_reg;
        mean_x_next = mean_x_reg;
        mean_y_next = mean_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        cross_next  = cross_reg;
        square_next = square_reg;
        slope_next  = slope_reg;
        icpt_next   = icpt_reg;
        sat_next    = sat_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (sample.last_point)
                    begin
                        // last pair: start the fit; if the store is full, fit what is there
                        n_next     = room ? (cnt_reg + CW'(1)) : cnt_reg;
                        cnt_next   = '0;
                        idx_next   = '0;
                        sumx_next  = '0;
                        sumy_next  = '0;
                        sat_next   = 1'b0;
                        state_next = S_RD1;
                    end
                end
            end
            S_RD1:
            begin
                state_next = S_ACC1;
            end
            S_ACC1:
            begin
                sumx_next = sumx_reg + {{(SW - 32){rd_x[31]}}, rd_x};
                sumy_next = sumy_reg + {{(SW - 32){rd_y[31]}}, rd_y};
                if (idx_reg == last_idx)
                begin
                    idx_next   = '0;
                    state_next = S_MX_GO;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RD1;
                end
            end
            S_MX_GO:
            begin
                state_next = S_MX_WT;
            end
            S_MX_WT:
            begin
                if (div_stat.done)
                begin
                    mean_x_next = div_q;
                    sat_next    = sat_reg | div_stat.sat;
                    state_next  = S_MY_GO;
                end
            end
            S_MY_GO:
            begin
                state_next = S_MY_WT;
            end
            S_MY_WT:
            begin
                if (div_stat.done)
                begin
                    mean_y_next = div_q;
                    sat_next    = sat_reg | div_stat.sat;
                    cross_next  = 64'd0;
                    square_next = 64'd0;
                    state_next  = S_RD2;
                end
            end
            S_RD2:
            begin
                state_next = S_DEV;
            end
            S_DEV:
            begin
                dx_next    = dx_s.val;
                dy_next    = dy_s.val;
                sat_next   = sat_reg | dx_s.sat | dy_s.sat;
                state_next = S_CR_GO;
            end
            S_CR_GO:
            begin
                state_next = S_CR_WT;
            end
            S_CR_WT:
            begin
                if (mul_stat.done)
                begin
                    cross_next = acc_s.val;
                    sat_next   = sat_reg | mul_stat.sat | acc_s.sat;
                    state_next = S_SQ_GO;
                end
            end
            S_SQ_GO:
            begin
                state_next = S_SQ_WT;
            end
            S_SQ_WT:
            begin
                if (mul_stat.done)
                begin
                    square_next = acc_s.val;
                    sat_next    = sat_reg | mul_stat.sat | acc_s.sat;
                    if (idx_reg == last_idx)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_RD2;
                    end
                end
            end
            S_CHK:
            begin
                if (square_reg == 64'd0)
                begin
                    // zero x variance: slope, intercept and forecast zero, status ST_ZERO_VAR
                    result_next.slope      = '0;
                    result_next.intercept  = '0;
                    result_next.forecast_y = '0;
                    result_next.fit_status = ST_ZERO_VAR;
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    state_next = S_SL_GO;
                end
            end
            S_SL_GO:
            begin
                state_next = S_SL_WT;
            end
            S_SL_WT:
            begin
                if (div_stat.done)
                begin
                    slope_next = div_q;
                    sat_next   = sat_reg | div_stat.sat;
                    state_next = S_IC_GO;
                end
            end
            S_IC_GO:
            begin
                state_next = S_IC_WT;
            end
            S_IC_WT:
            begin
                if (mul_stat.done)
                begin
                    icpt_next  = icpt_s.val;
                    sat_next   = sat_reg | mul_stat.sat | icpt_s.sat;
                    state_next = S_FY_GO;
                end
            end
            S_FY_GO:
            begin
                state_next = S_FY_WT;
            end
            S_FY_WT:
            begin
                if (mul_stat.done)
                begin
                    result_next.slope      = slope_reg;
                    result_next.intercept  = icpt_reg;
                    result_next.forecast_y = fy_s.val;
                    result_next.fit_status =
                        (sat_reg | mul_stat.sat | fy_s.sat) ? ST_SAT : ST_OK;
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            n_reg      <= '0;
            idx_reg    <= '0;
            sat_reg    <= 1'b0;
            done_reg   <= 1'b0;
            fx_reg     <= FORECAST_X_RESET;
            mean_x_reg <= 64'd0;
            mean_y_reg <= 64'd0;
            cross_reg  <= 64'd0;
            square_reg <= 64'd0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
            sat_reg    <= sat_next;
            done_reg   <= done_next;
            mean_x_reg <= mean_x_next;
            mean_y_reg <= mean_y_next;
            cross_reg  <= cross_next;
            square_reg <= square_next;
            if (cfg_valid && cfg_ready)
            begin
                fx_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sumx_reg   <= sumx_next;
        sumy_reg   <= sumy_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        slope_reg  <= slope_next;
        icpt_reg   <= icpt_next;
        result_reg <= result_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobe while the fit is still running");

    a_zero_var: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.fit_status == ST_ZERO_VAR)) |->
        ((result.slope == 0) && (result.intercept == 0) && (result.forecast_y == 0)))
        else $error("zero variance result carries nonzero fields");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |->
        ((state_reg == S_MX_WT) || (state_reg == S_MY_WT) || (state_reg == S_SL_WT)))
        else $error("divider finished outside a divide wait");

    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |->
        ((state_reg == S_CR_WT) || (state_reg == S_SQ_WT) ||
         (state_reg == S_IC_WT) || (state_reg == S_FY_WT)))
        else $error("multiplier finished outside a multiply wait");

endmodule

/* bench/least_squares_line_fit_test.sv */
// Self-checking testbench for the least-squares line fit: random sample sets, Q32.32 predictor.
`timescale 1ns / 1ps

module least_squares_line_fit_test;
    import lsf_pkg::*;

    // Store depth matches the block; longer sets overflow it on purpose.
    localparam int          FILL_DEPTH   = 64;
    // Slowest legal run: every request a one-pair set plus the longest sender gap,
    // plus a few store-full fits; taken ~6x over.
    localparam int          LIMIT_CYCLES = 2_000_000;
    localparam int          PHASES       = 7;
    localparam int          PHASE_ITEMS  = 155;
    // Quiet time after the last result; longer than one full-store fit.
    localparam int          END_SETTLE   = 2000;
    localparam logic [63:0] Q_TOP        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_BOTTOM     = 64'h8000_0000_0000_0000;

    typedef logic signed [63:0] q32_t;

    // Shapes of random sample sets. Most are well-formed lines or small clouds; the
    // wide ones drive the arithmetic into saturation, flat x gives zero variance.
    typedef enum int {SET_SMALL, SET_LINE, SET_WIDE, SET_FLAT_X, SET_MID, SET_EDGE} set_kind_t;

    // Fixed opening sets, run with the reset forecast_x (800000).
    localparam sample_t OPENING[22] = '{
        '{32'sd0, 32'sd0, 1'b1},                       // lone pair: zero variance
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1},       // lone pair at the extremes
        '{32'sd5, 32'sd1, 1'b0},                       // repeated x: zero variance
        '{32'sd5, 32'sd9, 1'b1},
        '{32'sd0, 32'sd1, 1'b0},                       // exact line y = 2x + 1
        '{32'sd1, 32'sd3, 1'b0},
        '{32'sd2, 32'sd5, 1'b1},
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0},       // full-range spread saturates
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1},
        '{32'sh8000_0000, 32'sh8000_0000, 1'b0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1},
        '{-32'sd3, 32'sd10, 1'b0},                     // falling line, slope -2
        '{32'sd0, 32'sd4, 1'b0},
        '{32'sd3, -32'sd2, 1'b0},
        '{32'sd6, -32'sd8, 1'b1},
        '{-32'sd1, -32'sd1, 1'b0},                     // y = x through zero
        '{32'sd0, 32'sd0, 1'b0},
        '{32'sd1, 32'sd1, 1'b1},
        '{32'sh7FFF_FFFF, 32'sd0, 1'b0},               // x at the top, step of one
        '{32'sh7FFF_FFFE, 32'sd1, 1'b1},
        '{32'sd0, 32'sh7FFF_FFFF, 1'b0},               // y jumps across the full range
        '{32'sd1, 32'sh8000_0000, 1'b1}
    };

    // Holds the expected fits and its own copy of the block state.
    class lsf_scoreboard;
        logic signed [31:0] x_mem[FILL_DEPTH];
        logic signed [31:0] y_mem[FILL_DEPTH];
        int unsigned        fill;
        logic [31:0]        forecast_x;
        result_t            fits_due[$];
        int                 errors;
        int                 fits_seen;
        bit                 sat_hit;

        function new();
            fill       = 0;
            forecast_x = FORECAST_X_RESET;
            errors     = 0;
            fits_seen  = 0;
        endfunction

        function int pending();
            return fits_due.size();
        endfunction

        function void note_config(logic [31:0] value);
            forecast_x = value;
        endfunction

        function logic [63:0] magnitude(q32_t a);
            return a[63] ? (~a + 64'd1) : a;
        endfunction

        // Clamp a magnitude to the signed range and apply the sign.
        function q32_t limit_mag(logic [63:0] m, bit neg, bit over);
            logic [63:0] lim;
            lim = neg ? Q_BOTTOM : Q_TOP;
            if (over || m > lim)
            begin
                sat_hit = 1'b1;
                m       = lim;
            end
            return neg ? q32_t'(~m + 64'd1) : q32_t'(m);
        endfunction

        function q32_t add_sat(q32_t a, q32_t b);
            logic [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
            begin
                sat_hit = 1'b1;
                return s[64] ? Q_BOTTOM : Q_TOP;
            end
            return s[63:0];
        endfunction

        function q32_t sub_sat(q32_t a, q32_t b);
            logic [64:0] s;
            s = {a[63], a} - {b[63], b};
            if (s[64] != s[63])
            begin
                sat_hit = 1'b1;
                return s[64] ? Q_BOTTOM : Q_TOP;
            end
            return s[63:0];
        endfunction

        // Exact product, shifted right by 32, truncated toward zero.
        function q32_t mul_q(q32_t a, q32_t b);
            logic [127:0] p;
            p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
            return limit_mag(p[95:32], a[63] ^ b[63], |p[127:96]);
        endfunction

        // (a << 32) / b truncated toward zero; divide by zero gives zero.
        function q32_t div_q(q32_t a, q32_t b);
            logic [127:0] q;
            if (b == 0)
                return 0;
            q = {32'd0, magnitude(a), 32'd0} / {64'd0, magnitude(b)};
            return limit_mag(q[63:0], a[63] ^ b[63], |q[127:64]);
        endfunction

        // Store the pair; on the last one of a set, work out the expected fit.
        function void note_sample(sample_t s);
            q32_t        sx, sy, mx, my, dx, dy, cs, ss, slope, icpt;
            result_t     r;
            int unsigned i;
            if (fill < FILL_DEPTH)
            begin
                x_mem[fill] = s.x_value;
                y_mem[fill] = s.y_value;
                fill++;
            end
            if (!s.last_point)
                return;
            sat_hit = 1'b0;
            sx      = 0;
            sy      = 0;
            for (i = 0; i < fill; i++)
            begin
                sx = sx + x_mem[i];
                sy = sy + y_mem[i];
            end
            mx = div_q(sx, q32_t'(fill));
            my = div_q(sy, q32_t'(fill));
            cs = 0;
            ss = 0;
            for (i = 0; i < fill; i++)
            begin
                dx = sub_sat({x_mem[i], 32'd0}, mx);
                dy = sub_sat({y_mem[i], 32'd0}, my);
                cs = add_sat(cs, mul_q(dx, dy));
                ss = add_sat(ss, mul_q(dx, dx));
            end
            fill = 0;
            if (ss == 0)
            begin
                r.slope      = 0;
                r.intercept  = 0;
                r.forecast_y = 0;
                r.fit_status = ST_ZERO_VAR;
            end
            else
            begin
                slope        = div_q(cs, ss);
                icpt         = sub_sat(my, mul_q(slope, mx));
                r.slope      = slope;
                r.intercept  = icpt;
                r.forecast_y = add_sat(icpt, mul_q(slope, {forecast_x, 32'd0}));
                r.fit_status = sat_hit ? ST_SAT : ST_OK;
            end
            fits_due.push_back(r);
        endfunction

        // One line per mismatch; after the first fifty only the count moves.
        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < 50)
                $display("mismatch in fit %0d: %s got %h want %h", fits_seen, what, got, want);
            errors++;
        endtask

        task check_fit(result_t got);
            result_t want;
            if (fits_due.size() == 0)
            begin
                report("unexpected result, slope", got.slope, 64'd0);
                return;
            end
            want = fits_due.pop_front();
            if (got.slope !== want.slope)
                report("slope", got.slope, want.slope);
            if (got.intercept !== want.intercept)
                report("intercept", got.intercept, want.intercept);
            if (got.forecast_y !== want.forecast_y)
                report("forecast_y", got.forecast_y, want.forecast_y);
            if (got.fit_status !== want.fit_status)
                report("fit_status", 64'(got.fit_status), 64'(want.fit_status));
            fits_seen++;
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    sample_t            sample = '0;
    logic               done;
    result_t            result;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic signed [31:0] cfg_data = '0;
    int unsigned        cycle_count = 0;
    lsf_scoreboard      sb;

    least_squares_line_fit #(
        .MAX_POINTS (FILL_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample     (sample),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watch both handshakes at each edge. Values read here are the pre-edge ones,
    // since every driver and the block update through nonblocking assignments.
    // A result is checked before a request at the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_fit(result);
            if (start && !busy)
                sb.note_sample(sample);
            if (cfg_valid && cfg_ready)
                sb.note_config(cfg_data);
        end
    end

    // Mostly back to back, often a short pause, now and then a long one.
    function automatic int gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] boundary_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Present one request and hold it until the block takes it (start high, busy low).
    // start is left high so a following request runs back to back.
    task automatic send_pair(logic signed [31:0] x, logic signed [31:0] y, bit last);
        start             <= 1'b1;
        sample.x_value    <= x;
        sample.y_value    <= y;
        sample.last_point <= last;
        do @(posedge clk); while (busy);
    endtask

    // Sender pause; junk on the payload while start is low.
    task automatic idle(int n);
        if (n > 0)
        begin
            start  <= 1'b0;
            sample <= {$urandom, $urandom, 1'($urandom)};
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every expected fit is back and the block is idle again.
    // It waits on the clock first, so a request taken at the current edge shows in busy.
    task automatic drain_fits();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_forecast(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One data set of len pairs, the last one marked. eager sets have no pauses.
    task automatic run_set(int len, set_kind_t kind, bit eager);
        logic signed [31:0] x, y, a, b, x0;
        int                 i;
        a  = int'($urandom_range(0, 100)) - 50;
        b  = int'($urandom_range(0, 20000)) - 10000;
        x0 = $urandom;
        for (i = 0; i < len; i++)
        begin
            case (kind)
                SET_SMALL:
                begin
                    x = int'($urandom_range(0, 2000)) - 1000;
                    y = int'($urandom_range(0, 2000)) - 1000;
                end
                SET_LINE:
                begin
                    x = int'($urandom_range(0, 200000)) - 100000;
                    y = a * x + b + int'($urandom_range(0, 6)) - 3;
                end
                SET_WIDE:
                begin
                    x = $urandom;
                    y = $urandom;
                end
                SET_FLAT_X:
                begin
                    x = x0;
                    y = $urandom;
                end
                SET_MID:
                begin
                    x = int'($urandom_range(0, 2097152)) - 1048576;
                    y = $urandom;
                end
                default:
                begin
                    x = boundary_value();
                    y = boundary_value();
                end
            endcase
            send_pair(x, y, i == len - 1);
            if (!eager)
                idle(gap_cycles());
        end
    endtask

    initial
    begin
        int          phase_items, len, k, r;
        logic [31:0] plan[PHASES];
        set_kind_t   kind;

        sb      = new();
        // forecast_x settings per phase: zero, both extremes, minus one, one, two random values
        plan[0] = 32'd0;
        plan[1] = 32'h7FFF_FFFF;
        plan[2] = 32'h8000_0000;
        plan[3] = 32'hFFFF_FFFF;
        plan[4] = 32'd1;
        plan[5] = $urandom;
        plan[6] = int'($urandom_range(0, 2000000)) - 1000000;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening sets under the reset forecast_x.
        foreach (OPENING[k])
        begin
            send_pair(OPENING[k].x_value, OPENING[k].y_value, OPENING[k].last_point);
            idle(gap_cycles());
        end
        drain_fits();

        // Random sets, one forecast_x per phase; written only with the block idle.
        for (k = 0; k < PHASES; k++)
        begin
            write_forecast(plan[k]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    len = $urandom_range(FILL_DEPTH, FILL_DEPTH + 8);  // fills or overflows the store
                else if (r < 12)
                    len = $urandom_range(1, 2);
                else
                    len = $urandom_range(3, 12);
                r = $urandom_range(0, 99);
                if (r < 25)
                    kind = SET_SMALL;
                else if (r < 60)
                    kind = SET_LINE;
                else if (r < 70)
                    kind = SET_WIDE;
                else if (r < 78)
                    kind = SET_FLAT_X;
                else if (r < 90)
                    kind = SET_MID;
                else
                    kind = SET_EDGE;
                run_set(len, kind, $urandom_range(0, 3) == 0);
                phase_items += (len > FILL_DEPTH) ? FILL_DEPTH : len;
                // now and then let everything come back before the next set
                if ($urandom_range(0, 19) == 0)
                    drain_fits();
            end
            drain_fits();
        end

        // Catch any stray result after the last expected one.
        repeat (END_SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS least_squares_line_fit");
        else
            $display("FAIL least_squares_line_fit");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d fits outstanding", cycle_count, sb.pending());
        $display("FAIL least_squares_line_fit");
        $finish;
    end

endmodule
